FILE: hdl/pwrseq_pkg.sv
package pwrseq_pkg;

	localparam int CNT_W = 16;
	localparam int LIM_W = 16;
	localparam int CMP_W = (CNT_W > LIM_W) ? CNT_W : LIM_W;
	localparam int BLINK_W = 16;
	localparam int HALF_W = 15;
	localparam int IDX_W = 3;
	localparam int CFG_DATA_W = 16;
	localparam int IN_DATA_W = 8;
	localparam int OUT_DATA_W = 32;

	localparam logic [CNT_W-1:0] CNT_MAX = '1;
	localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

	typedef enum logic [3:0] {
		ST_IDLE        = 4'd0,
		ST_TURN_ON     = 4'd1,
		ST_WAIT_CONN   = 4'd2,
		ST_WAIT_STABLE = 4'd3,
		ST_TURN_OFF    = 4'd4,
		ST_WAIT_DISC   = 4'd5,
		ST_RELAY       = 4'd6,
		ST_ERR_ON      = 4'd7,
		ST_ERR_OFF     = 4'd8
	} seq_state_t;

	typedef enum logic [1:0] {
		LED_OFF    = 2'd0,
		LED_RED    = 2'd1,
		LED_GREEN  = 2'd2,
		LED_YELLOW = 2'd3
	} led_t;

	typedef enum logic {
		OP_TICK    = 1'b0,
		OP_REQUEST = 1'b1
	} opcode_t;

	typedef enum logic [IDX_W-1:0] {
		REG_CONNECT_TO    = 3'd0,
		REG_DISCONNECT_TO = 3'd1,
		REG_STABLE        = 3'd2,
		REG_RELAY_DELAY   = 3'd3,
		REG_ERROR_HOLD    = 3'd4,
		REG_BLINK_HALF    = 3'd5,
		REG_HOST_INST     = 3'd6,
		REG_ON_DUTY       = 3'd7
	} reg_idx_t;

	typedef struct packed {
		logic [LIM_W-1:0]  connect_timeout_ms;
		logic [LIM_W-1:0]  disconnect_timeout_ms;
		logic [LIM_W-1:0]  stable_ms;
		logic [LIM_W-1:0]  relay_delay;
		logic [LIM_W-1:0]  error_hold_ms;
		logic [HALF_W-1:0] blink_half_ms;
		logic              host_installed;
		logic [15:0]       on_duty;
	} cfg_t;

	typedef struct packed {
		logic        busy_res;
		logic        power_is_on;
		logic        powerdown_pulse;
		logic        host_switch;
		logic [15:0] pwm_duty;
		led_t        led_colour;
		seq_state_t  seq_state;
	} res_t;

	function automatic logic [CMP_W-1:0] clip_lim(input logic [LIM_W-1:0] lim);
		logic [CMP_W-1:0] l;
		logic [CMP_W-1:0] m;
		l = CMP_W'(lim);
		m = CMP_W'(CNT_MAX);
		return (l > m) ? m : l;
	endfunction

	function automatic logic reached(input logic [CNT_W-1:0] el, input logic [LIM_W-1:0] lim);
		return CMP_W'(el) >= clip_lim(lim);
	endfunction

	function automatic logic timed_out(input logic [CNT_W-1:0] el,
			input logic [LIM_W-1:0] lim);
		return (CMP_W'(el) > clip_lim(lim)) || (el == CNT_MAX);
	endfunction

endpackage

FILE: hdl/power_sequencer_fsm_core.sv
// An accepted request waits in the input register; its result is registered for m_axis.
// One request per cycle while m_axis_tready is high; input and result register each hold one.
// A stalled result register holds the input register, which still accepts while empty.
// Reset (arst_n low, asynchronous): sequencer idle, counters, LED, duty and
// host switch cleared, registers back to their defaults, both stages empty.
module power_sequencer_fsm_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// [0] turn_on, [1] host_running, [7:2] zero
	input  logic [pwrseq_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// [0] opcode
	input  logic                                s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [3:0] seq_state, [5:4] led_colour, [21:6] pwm_duty, [22] host_switch,
	// [23] powerdown_pulse, [24] power_is_on, [25] busy_res, [31:26] zero
	output logic [pwrseq_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pwrseq_pkg::IDX_W-1:0]        cfg_index,
	input  logic [pwrseq_pkg::CFG_DATA_W-1:0]   cfg_data
);

	pwrseq_pkg::cfg_t cfg;
	pwrseq_pkg::res_t res;

	logic valid_s1, opcode_s1, turn_on_s1, running_s1;
	logic valid_s2;
	logic [pwrseq_pkg::OUT_DATA_W-1:0] tdata_s2;
	logic advance, in_take;

	assign cfg_ready     = 1'b1;
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign in_take       = s_axis_tvalid && s_axis_tready;

	pwrseq_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	pwrseq_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.opcode       (opcode_s1),
		.turn_on      (turn_on_s1),
		.host_running (running_s1),
		.cfg          (cfg),
		.res          (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_take)
				valid_s1 <= 1'b1;
			else if (advance)
				valid_s1 <= 1'b0;
			if (advance)
				valid_s2 <= 1'b1;
			else if (m_axis_tready)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			opcode_s1  <= s_axis_tuser;
			turn_on_s1 <= s_axis_tdata[0];
			running_s1 <= s_axis_tdata[1];
		end
		if (advance)
			tdata_s2 <= {6'd0, res};
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = tdata_s2;

endmodule

FILE: hdl/pwrseq_cfg.sv
module pwrseq_cfg (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [pwrseq_pkg::IDX_W-1:0]       wr_index,
	input  logic [pwrseq_pkg::CFG_DATA_W-1:0]  wr_data,
	output pwrseq_pkg::cfg_t                   cfg
);

	pwrseq_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.connect_timeout_ms    <= 16'd15000;
			cfg_q.disconnect_timeout_ms <= 16'd20000;
			cfg_q.stable_ms             <= 16'd2000;
			cfg_q.relay_delay           <= 16'd5000;
			cfg_q.error_hold_ms         <= 16'd3000;
			cfg_q.blink_half_ms         <= 15'd250;
			cfg_q.host_installed        <= 1'b1;
			cfg_q.on_duty               <= 16'd720;
		end else if (wr_en) begin
			unique case (pwrseq_pkg::reg_idx_t'(wr_index))
				pwrseq_pkg::REG_CONNECT_TO:    cfg_q.connect_timeout_ms <= wr_data;
				pwrseq_pkg::REG_DISCONNECT_TO: cfg_q.disconnect_timeout_ms <= wr_data;
				pwrseq_pkg::REG_STABLE:        cfg_q.stable_ms <= wr_data;
				pwrseq_pkg::REG_RELAY_DELAY:   cfg_q.relay_delay <= wr_data;
				pwrseq_pkg::REG_ERROR_HOLD:    cfg_q.error_hold_ms <= wr_data;
				pwrseq_pkg::REG_BLINK_HALF:
					cfg_q.blink_half_ms <= wr_data[pwrseq_pkg::HALF_W-1:0];
				pwrseq_pkg::REG_HOST_INST:     cfg_q.host_installed <= wr_data[0];
				pwrseq_pkg::REG_ON_DUTY:       cfg_q.on_duty <= wr_data;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hdl/pwrseq_core.sv
module pwrseq_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic                opcode,
	input  logic                turn_on,
	input  logic                host_running,
	input  pwrseq_pkg::cfg_t    cfg,
	output pwrseq_pkg::res_t    res
);

	pwrseq_pkg::seq_state_t state_q, state_d;
	logic [pwrseq_pkg::CNT_W-1:0]   elapsed_q, elapsed_d, el_inc;
	logic [pwrseq_pkg::BLINK_W-1:0] blink_q, blink_d, bl_inc;
	logic [pwrseq_pkg::BLINK_W:0]   bl_next;
	logic [pwrseq_pkg::BLINK_W-1:0] period;
	logic                           pon_q, pon_d;
	pwrseq_pkg::led_t               led_q, led_d;
	logic [15:0]                    duty_q, duty_d;
	logic                           hs_q, hs_d;
	logic                           pulse;
	logic                           tick, req, blink_off;

	assign tick = step && (pwrseq_pkg::opcode_t'(opcode) == pwrseq_pkg::OP_TICK);
	assign req  = step && (pwrseq_pkg::opcode_t'(opcode) == pwrseq_pkg::OP_REQUEST);

	assign el_inc    = (elapsed_q == pwrseq_pkg::CNT_MAX) ? elapsed_q
	                 : elapsed_q + pwrseq_pkg::CNT_ONE;
	assign period    = {cfg.blink_half_ms, 1'b0};
	assign bl_next   = {1'b0, blink_q} + 17'd1;
	assign bl_inc    = (bl_next >= {1'b0, period}) ? '0 : bl_next[pwrseq_pkg::BLINK_W-1:0];
	assign blink_off = bl_inc < {1'b0, cfg.blink_half_ms};

	// next state
	always_comb begin
		state_d = state_q;
		if (req) begin
			if (state_q == pwrseq_pkg::ST_IDLE && turn_on != pon_q)
				state_d = turn_on ? pwrseq_pkg::ST_TURN_ON : pwrseq_pkg::ST_TURN_OFF;
		end else if (tick) begin
			unique case (state_q)
				pwrseq_pkg::ST_IDLE: ;
				pwrseq_pkg::ST_TURN_ON:
					state_d = cfg.host_installed ? pwrseq_pkg::ST_WAIT_CONN
					                             : pwrseq_pkg::ST_WAIT_STABLE;
				pwrseq_pkg::ST_WAIT_CONN: begin
					if (host_running)
						state_d = pwrseq_pkg::ST_WAIT_STABLE;
					else if (pwrseq_pkg::timed_out(el_inc, cfg.connect_timeout_ms))
						state_d = pwrseq_pkg::ST_ERR_ON;
				end
				pwrseq_pkg::ST_WAIT_STABLE: begin
					if (pwrseq_pkg::reached(el_inc, cfg.stable_ms))
						state_d = pwrseq_pkg::ST_IDLE;
				end
				pwrseq_pkg::ST_TURN_OFF:
					state_d = cfg.host_installed ? pwrseq_pkg::ST_WAIT_DISC
					                             : pwrseq_pkg::ST_RELAY;
				pwrseq_pkg::ST_WAIT_DISC: begin
					if (!host_running)
						state_d = pwrseq_pkg::ST_RELAY;
					else if (pwrseq_pkg::timed_out(el_inc, cfg.disconnect_timeout_ms))
						state_d = pwrseq_pkg::ST_ERR_OFF;
				end
				pwrseq_pkg::ST_RELAY: begin
					if (pwrseq_pkg::reached(el_inc, cfg.relay_delay))
						state_d = pwrseq_pkg::ST_IDLE;
				end
				pwrseq_pkg::ST_ERR_ON, pwrseq_pkg::ST_ERR_OFF: begin
					if (pwrseq_pkg::reached(el_inc, cfg.error_hold_ms))
						state_d = pwrseq_pkg::ST_IDLE;
				end
				default: ;
			endcase
		end
	end

	// outputs and counters; every state change restarts both counters
	always_comb begin
		elapsed_d = elapsed_q;
		blink_d   = blink_q;
		pon_d     = pon_q;
		led_d     = led_q;
		duty_d    = duty_q;
		hs_d      = hs_q;
		pulse     = 1'b0;
		if (tick) begin
			elapsed_d = el_inc;
			blink_d   = bl_inc;
			unique case (state_q)
				pwrseq_pkg::ST_IDLE: ;
				pwrseq_pkg::ST_TURN_ON: begin
					duty_d = cfg.on_duty;
					if (cfg.host_installed)
						hs_d = 1'b1;
				end
				pwrseq_pkg::ST_WAIT_CONN, pwrseq_pkg::ST_WAIT_DISC:
					led_d = blink_off ? pwrseq_pkg::LED_OFF : pwrseq_pkg::LED_YELLOW;
				pwrseq_pkg::ST_WAIT_STABLE, pwrseq_pkg::ST_ERR_OFF: begin
					led_d = blink_off ? pwrseq_pkg::LED_OFF : pwrseq_pkg::LED_GREEN;
					if (state_d == pwrseq_pkg::ST_IDLE) begin
						led_d = pwrseq_pkg::LED_GREEN;
						pon_d = 1'b1;
					end
				end
				pwrseq_pkg::ST_TURN_OFF:
					pulse = cfg.host_installed;
				pwrseq_pkg::ST_RELAY, pwrseq_pkg::ST_ERR_ON: begin
					if (state_q == pwrseq_pkg::ST_RELAY)
						led_d = blink_off ? pwrseq_pkg::LED_OFF : pwrseq_pkg::LED_YELLOW;
					else
						led_d = blink_off ? pwrseq_pkg::LED_OFF : pwrseq_pkg::LED_RED;
					if (state_d == pwrseq_pkg::ST_IDLE) begin
						duty_d = '0;
						hs_d   = 1'b0;
						led_d  = pwrseq_pkg::LED_YELLOW;
						pon_d  = 1'b0;
					end
				end
				default: ;
			endcase
		end
		if (state_d != state_q) begin
			elapsed_d = '0;
			blink_d   = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= pwrseq_pkg::ST_IDLE;
			elapsed_q <= '0;
			blink_q   <= '0;
			pon_q     <= 1'b0;
			led_q     <= pwrseq_pkg::LED_OFF;
			duty_q    <= '0;
			hs_q      <= 1'b0;
		end else if (step) begin
			state_q   <= state_d;
			elapsed_q <= elapsed_d;
			blink_q   <= blink_d;
			pon_q     <= pon_d;
			led_q     <= led_d;
			duty_q    <= duty_d;
			hs_q      <= hs_d;
		end
	end

	always_comb begin
		res.seq_state       = state_d;
		res.led_colour      = led_d;
		res.pwm_duty        = duty_d;
		res.host_switch     = hs_d;
		res.powerdown_pulse = pulse;
		res.power_is_on     = pon_d;
		res.busy_res        = (state_d != pwrseq_pkg::ST_IDLE);
	end

endmodule

FILE: hdl/pwrseq_chk.sv
module pwrseq_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata
);

	a_busy_matches_state: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |->
			(m_axis_tdata[25] == (m_axis_tdata[3:0] != pwrseq_pkg::ST_IDLE)))
		else $error("busy flag disagrees with state");

	a_state_legal: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[3:0] <= pwrseq_pkg::ST_ERR_OFF))
		else $error("state code out of range");

	a_pulse_in_disc_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[23]) |->
			(m_axis_tdata[3:0] == pwrseq_pkg::ST_WAIT_DISC))
		else $error("power-down pulse outside disconnect wait");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("stalled result changed");

endmodule

bind power_sequencer_fsm_core pwrseq_chk u_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

FILE: tb/tb_power_sequencer_fsm_core.sv
`timescale 1ns / 100ps

module tb_power_sequencer_fsm_core;

	localparam int QUIET_LIMIT = 3000;
	localparam int IN_W = pwrseq_pkg::IN_DATA_W;
	localparam int OUT_W = pwrseq_pkg::OUT_DATA_W;

	typedef struct {
		pwrseq_pkg::opcode_t op;
		logic                ton;
		logic                run;
		bit                  drain_first;
	} seq_item_t;

	logic                                  clk = 1'b0;
	logic                                  arst_n = 1'b0;
	logic                                  s_axis_tvalid = 1'b0;
	logic                                  s_axis_tready;
	// [0] turn_on, [1] host_running, [7:2] zero
	logic [IN_W-1:0]                       s_axis_tdata = '0;
	// [0] opcode
	logic                                  s_axis_tuser = 1'b0;
	logic                                  m_axis_tvalid;
	logic                                  m_axis_tready = 1'b0;
	// [3:0] seq_state, [5:4] led_colour, [21:6] pwm_duty, [22] host_switch,
	// [23] powerdown_pulse, [24] power_is_on, [25] busy_res, [31:26] zero
	logic [OUT_W-1:0]                      m_axis_tdata;
	logic                                  cfg_valid = 1'b0;
	logic                                  cfg_ready;
	logic [pwrseq_pkg::IDX_W-1:0]          cfg_index = '0;
	logic [pwrseq_pkg::CFG_DATA_W-1:0]     cfg_data = '0;

	// sequencer copy, reset values
	logic [15:0] lim_connect = 16'd15000;
	logic [15:0] lim_disconnect = 16'd20000;
	logic [15:0] lim_stable = 16'd2000;
	logic [15:0] lim_relay = 16'd5000;
	logic [15:0] lim_hold = 16'd3000;
	logic [14:0] blink_half = 15'd250;
	logic        host_fitted = 1'b1;
	logic [15:0] duty_on = 16'd720;

	pwrseq_pkg::seq_state_t seq_st = pwrseq_pkg::ST_IDLE;
	logic [15:0]            elapsed_ms = '0;
	logic [15:0]            blink_ph = '0;
	logic                   rec_power_on = 1'b0;
	pwrseq_pkg::led_t       led_now = pwrseq_pkg::LED_OFF;
	logic [15:0]            duty_now = '0;
	logic                   host_key = 1'b0;

	seq_item_t        tick_req_q[$];
	pwrseq_pkg::res_t expected_status[$];
	seq_item_t        next_item;
	int               in_gap = 0;
	int               out_stall = 0;
	int               quiet_cycles = 0;
	int               errors = 0;
	int               checked = 0;
	int               pushed = 0;
	bit               idle_gaps = 1'b1;
	logic             power_guess = 1'b0;

	power_sequencer_fsm_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	function automatic void enter_state(pwrseq_pkg::seq_state_t s);
		seq_st = s;
		elapsed_ms = '0;
		blink_ph = '0;
	endfunction

	function automatic pwrseq_pkg::led_t blink_colour(pwrseq_pkg::led_t c);
		return (blink_ph < {1'b0, blink_half}) ? pwrseq_pkg::LED_OFF : c;
	endfunction

	function automatic bit wait_expired(logic [15:0] lim);
		return (elapsed_ms > lim) || (&elapsed_ms);
	endfunction

	function automatic pwrseq_pkg::res_t sequencer_next(pwrseq_pkg::opcode_t op,
			logic ton, logic run);
		pwrseq_pkg::res_t r;
		logic             pulse;
		int               period;
		int               nb;
		bit               relay;
		logic [15:0]      lim;
		pulse = 1'b0;
		if (op == pwrseq_pkg::OP_REQUEST) begin
			if (seq_st == pwrseq_pkg::ST_IDLE && ton != rec_power_on) begin
				if (ton)
					enter_state(pwrseq_pkg::ST_TURN_ON);
				else
					enter_state(pwrseq_pkg::ST_TURN_OFF);
			end
		end else begin
			period = 2 * int'(blink_half);
			nb = int'(blink_ph) + 1;
			if (!(&elapsed_ms))
				elapsed_ms++;
			blink_ph = (nb >= period) ? 16'd0 : 16'(nb);
			case (seq_st)
				pwrseq_pkg::ST_TURN_ON: begin
					duty_now = duty_on;
					if (host_fitted) begin
						host_key = 1'b1;
						enter_state(pwrseq_pkg::ST_WAIT_CONN);
					end else begin
						enter_state(pwrseq_pkg::ST_WAIT_STABLE);
					end
				end
				pwrseq_pkg::ST_WAIT_CONN: begin
					led_now = blink_colour(pwrseq_pkg::LED_YELLOW);
					if (run)
						enter_state(pwrseq_pkg::ST_WAIT_STABLE);
					else if (wait_expired(lim_connect))
						enter_state(pwrseq_pkg::ST_ERR_ON);
				end
				pwrseq_pkg::ST_WAIT_STABLE, pwrseq_pkg::ST_ERR_OFF: begin
					led_now = blink_colour(pwrseq_pkg::LED_GREEN);
					lim = (seq_st == pwrseq_pkg::ST_WAIT_STABLE) ? lim_stable : lim_hold;
					if (elapsed_ms >= lim) begin
						led_now = pwrseq_pkg::LED_GREEN;
						rec_power_on = 1'b1;
						enter_state(pwrseq_pkg::ST_IDLE);
					end
				end
				pwrseq_pkg::ST_TURN_OFF: begin
					if (host_fitted) begin
						pulse = 1'b1;
						enter_state(pwrseq_pkg::ST_WAIT_DISC);
					end else begin
						enter_state(pwrseq_pkg::ST_RELAY);
					end
				end
				pwrseq_pkg::ST_WAIT_DISC: begin
					led_now = blink_colour(pwrseq_pkg::LED_YELLOW);
					if (!run)
						enter_state(pwrseq_pkg::ST_RELAY);
					else if (wait_expired(lim_disconnect))
						enter_state(pwrseq_pkg::ST_ERR_OFF);
				end
				pwrseq_pkg::ST_RELAY, pwrseq_pkg::ST_ERR_ON: begin
					relay = (seq_st == pwrseq_pkg::ST_RELAY);
					led_now = blink_colour(relay ? pwrseq_pkg::LED_YELLOW
					                             : pwrseq_pkg::LED_RED);
					if (elapsed_ms >= (relay ? lim_relay : lim_hold)) begin
						duty_now = '0;
						host_key = 1'b0;
						led_now = pwrseq_pkg::LED_YELLOW;
						rec_power_on = 1'b0;
						enter_state(pwrseq_pkg::ST_IDLE);
					end
				end
				default: ;
			endcase
		end
		r.seq_state = seq_st;
		r.led_colour = led_now;
		r.pwm_duty = duty_now;
		r.host_switch = host_key;
		r.powerdown_pulse = pulse;
		r.power_is_on = rec_power_on;
		r.busy_res = (seq_st != pwrseq_pkg::ST_IDLE);
		return r;
	endfunction

	task automatic report(string msg);
		errors++;
		$display("MISMATCH status %0d: %s", checked, msg);
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	task automatic compare_status(pwrseq_pkg::res_t want, logic [OUT_W-1:0] word);
		pwrseq_pkg::res_t got;
		got = pwrseq_pkg::res_t'(word[$bits(pwrseq_pkg::res_t)-1:0]);
		check_field("seq_state", 32'(got.seq_state), 32'(want.seq_state));
		check_field("led_colour", 32'(got.led_colour), 32'(want.led_colour));
		check_field("pwm_duty", 32'(got.pwm_duty), 32'(want.pwm_duty));
		check_field("host_switch", 32'(got.host_switch), 32'(want.host_switch));
		check_field("powerdown_pulse", 32'(got.powerdown_pulse),
			32'(want.powerdown_pulse));
		check_field("power_is_on", 32'(got.power_is_on), 32'(want.power_is_on));
		check_field("busy_res", 32'(got.busy_res), 32'(want.busy_res));
		check_field("padding", 32'(word[OUT_W-1:$bits(pwrseq_pkg::res_t)]), '0);
	endtask

	// request driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_status.push_back(sequencer_next(
					pwrseq_pkg::opcode_t'(s_axis_tuser), s_axis_tdata[0], s_axis_tdata[1]));
				in_gap = idle_gaps ? $urandom_range(0, 6) : 0;
			end
			if (!s_axis_tvalid || s_axis_tready) begin
				if (in_gap > 0) begin
					in_gap--;
					s_axis_tvalid <= 1'b0;
				end else if (tick_req_q.size() > 0 &&
						!(tick_req_q[0].drain_first && expected_status.size() > 0)) begin
					next_item = tick_req_q.pop_front();
					s_axis_tuser <= next_item.op;
					s_axis_tdata <= {6'b0, next_item.run, next_item.ton};
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// status monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_status.size() == 0)
					report("status word with nothing expected");
				else
					compare_status(expected_status.pop_front(), m_axis_tdata);
				checked++;
				out_stall = idle_gaps ? $urandom_range(0, 6) : 0;
			end
			if (out_stall > 0) begin
				m_axis_tready <= 1'b0;
				if (m_axis_tvalid)
					out_stall--;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	task automatic push_item(pwrseq_pkg::opcode_t op, logic ton, logic run, bit drain_first);
		seq_item_t it;
		it.op = op;
		it.ton = ton;
		it.run = run;
		it.drain_first = drain_first;
		tick_req_q.push_back(it);
		pushed++;
	endtask

	task automatic push_ticks(int n, int run_pct);
		repeat (n)
			push_item(pwrseq_pkg::OP_TICK, 1'($urandom), $urandom_range(0, 99) < run_pct,
				1'b0);
	endtask

	task automatic write_reg(pwrseq_pkg::reg_idx_t idx, logic [15:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			pwrseq_pkg::REG_CONNECT_TO:    lim_connect = val;
			pwrseq_pkg::REG_DISCONNECT_TO: lim_disconnect = val;
			pwrseq_pkg::REG_STABLE:        lim_stable = val;
			pwrseq_pkg::REG_RELAY_DELAY:   lim_relay = val;
			pwrseq_pkg::REG_ERROR_HOLD:    lim_hold = val;
			pwrseq_pkg::REG_BLINK_HALF:    blink_half = val[14:0];
			pwrseq_pkg::REG_HOST_INST:     host_fitted = val[0];
			pwrseq_pkg::REG_ON_DUTY:       duty_on = val;
			default: ;
		endcase
	endtask

	task automatic set_config(logic [15:0] conn, logic [15:0] disc, logic [15:0] stab,
			logic [15:0] relay, logic [15:0] hold, logic [14:0] half, logic host,
			logic [15:0] duty);
		write_reg(pwrseq_pkg::REG_CONNECT_TO, conn);
		write_reg(pwrseq_pkg::REG_DISCONNECT_TO, disc);
		write_reg(pwrseq_pkg::REG_STABLE, stab);
		write_reg(pwrseq_pkg::REG_RELAY_DELAY, relay);
		write_reg(pwrseq_pkg::REG_ERROR_HOLD, hold);
		write_reg(pwrseq_pkg::REG_BLINK_HALF, {1'($urandom), half});
		write_reg(pwrseq_pkg::REG_HOST_INST, {15'($urandom), host});
		write_reg(pwrseq_pkg::REG_ON_DUTY, duty);
	endtask

	// block is idle and every status word is in
	task automatic wait_drained();
		do @(negedge clk);
		while (tick_req_q.size() != 0 || s_axis_tvalid || expected_status.size() != 0);
		repeat (4) @(negedge clk);
		power_guess = rec_power_on;
	endtask

	// one power request and enough ticks to finish it, or a cut-short run
	task automatic add_sequence();
		logic ton;
		int   need;
		int   pct;
		int   longest;
		ton = !power_guess;
		power_guess = ton;
		if (ton) begin
			longest = (lim_stable > lim_hold) ? int'(lim_stable) : int'(lim_hold);
			need = 3 + (host_fitted ? int'(lim_connect) + 2 : 0) + longest + 1;
			pct = $urandom_range(0, 60);
		end else begin
			longest = (lim_relay > lim_hold) ? int'(lim_relay) : int'(lim_hold);
			need = 3 + (host_fitted ? int'(lim_disconnect) + 2 : 0) + longest + 1;
			pct = $urandom_range(40, 100);
		end
		push_item(pwrseq_pkg::OP_REQUEST, ton, 1'($urandom), $urandom_range(0, 49) == 0);
		if ($urandom_range(0, 99) < 85)
			push_ticks(need + $urandom_range(0, 3), pct);
		else
			push_ticks($urandom_range(0, need), pct);
	endtask

	task automatic random_phase(int n);
		int stop;
		stop = pushed + n;
		while (pushed < stop) begin
			if ($urandom_range(0, 99) < 20)
				repeat ($urandom_range(1, 3))
					push_item(pwrseq_pkg::opcode_t'($urandom_range(0, 1)), 1'($urandom),
						1'($urandom), 1'b0);
			else
				add_sequence();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// default registers: power-on into the long stabilization wait
		push_item(pwrseq_pkg::OP_TICK, 1'b0, 1'b0, 1'b0);
		push_item(pwrseq_pkg::OP_REQUEST, 1'b0, 1'b1, 1'b0);
		push_item(pwrseq_pkg::OP_TICK, 1'b1, 1'b1, 1'b0);
		push_item(pwrseq_pkg::OP_REQUEST, 1'b1, 1'b0, 1'b0);
		push_item(pwrseq_pkg::OP_TICK, 1'b0, 1'b0, 1'b0);
		push_item(pwrseq_pkg::OP_REQUEST, 1'b0, 1'b1, 1'b0);
		push_item(pwrseq_pkg::OP_TICK, 1'b0, 1'b1, 1'b0);
		push_ticks(300, 50);
		push_item(pwrseq_pkg::OP_REQUEST, 1'b1, 1'b1, 1'b0);
		wait_drained();

		// end of the stabilization wait, clean off, clean on, disconnect timeout, clean off
		set_config(16'd3, 16'd3, 16'd2, 16'd2, 16'd2, 15'd1, 1'b1, 16'hFFFF);
		push_item(pwrseq_pkg::OP_REQUEST, 1'b1, 1'b0, 1'b0);
		push_item(pwrseq_pkg::OP_TICK, 1'b0, 1'b0, 1'b0);
		push_item(pwrseq_pkg::OP_REQUEST, 1'b0, 1'b0, 1'b0);
		push_ticks(7, 0);
		push_item(pwrseq_pkg::OP_REQUEST, 1'b1, 1'b1, 1'b0);
		push_item(pwrseq_pkg::OP_TICK, 1'b1, 1'b0, 1'b0);
		push_ticks(4, 100);
		push_item(pwrseq_pkg::OP_REQUEST, 1'b1, 1'b0, 1'b0);
		push_item(pwrseq_pkg::OP_REQUEST, 1'b0, 1'b1, 1'b1);
		push_ticks(8, 100);
		push_item(pwrseq_pkg::OP_REQUEST, 1'b0, 1'b1, 1'b0);
		push_item(pwrseq_pkg::OP_TICK, 1'b1, 1'b1, 1'b0);
		push_ticks(4, 0);
		wait_drained();

		// host not fitted, zero limits, zero blink half
		set_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 15'd0, 1'b0, 16'd0);
		random_phase(150);

		for (int ph = 0; ph < 6; ph++) begin
			wait_drained();
			idle_gaps = (ph != 3);
			set_config(16'($urandom_range(0, 12)), 16'($urandom_range(0, 12)),
				16'($urandom_range(0, 12)), 16'($urandom_range(0, 12)),
				16'($urandom_range(0, 12)), 15'($urandom_range(0, 5)),
				1'($urandom_range(0, 1)), 16'($urandom));
			random_phase(200);
		end
		wait_drained();
		repeat (8) @(posedge clk);

		if (errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

FILE: sim.f
hdl/pwrseq_pkg.sv
hdl/pwrseq_cfg.sv
hdl/pwrseq_core.sv
hdl/power_sequencer_fsm_core.sv
hdl/pwrseq_chk.sv
tb/tb_power_sequencer_fsm_core.sv
